// ----- hdl/epoch_to_calendar_time_macros.svh -----
// assertion macros shared by the epoch to calendar time rtl
`ifndef EPOCH_TO_CALENDAR_TIME_MACROS_SVH
`define EPOCH_TO_CALENDAR_TIME_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define E2CT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define E2CT_IMPLY_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/e2ct_pkg.sv -----
// types, constants and microcode rom for the epoch to calendar time converter
package e2ct_pkg;

  // field widths
  localparam int EpochW  = 32;
  localparam int YearW   = 12;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;

  // internal widths
  localparam int DaysW = 17;  // whole days since epoch, at most 49710
  localparam int CandW = 34;  // quotient times divisor, 17 by 17 bits

  // calendar constants
  localparam logic [DaysW-1:0]  SecsPerDay    = 17'd86400;
  localparam logic [DaysW-1:0]  SecsPerHour   = 17'd3600;
  localparam logic [DaysW-1:0]  SecsPerMin    = 17'd60;
  localparam logic [YearW-1:0]  FirstYear     = 12'd1970;
  localparam logic [8:0]        DaysLeapYear  = 9'd366;
  localparam logic [8:0]        DaysYear      = 9'd365;
  localparam logic [MonthW-1:0] MonthsPerYear = 4'd12;
  localparam logic [MonthW-1:0] MonthJan      = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb      = 4'd2;

  // year residues kept as counters for the leap test
  localparam logic [1:0] Y4Init   = 2'(FirstYear % 4);
  localparam logic [6:0] Y100Init = 7'(FirstYear % 100);
  localparam logic [8:0] Y400Init = 9'(FirstYear % 400);
  localparam logic [6:0] Y100Last = 7'd99;
  localparam logic [8:0] Y400Last = 9'd399;

  // reciprocal quotients: q = (x * recip) >> shift, exact over the whole x range
  // days: 86400 = 675 << 7, x = seconds >> 7 below 2^25
  localparam int          DayPreShift = 7;
  localparam int          DayShift    = 35;
  localparam int          DayProdW    = 51;
  localparam logic [25:0] DayRecip    = 26'd50903317;
  // hours: x = seconds of the day below 2^17
  localparam int          HourInW     = 17;
  localparam int          HourShift   = 29;
  localparam int          HourProdW   = 35;
  localparam logic [17:0] HourRecip   = 18'd149131;
  // minutes: x = seconds of the hour below 2^12
  localparam int          MinInW      = 12;
  localparam int          MinShift    = 18;
  localparam int          MinProdW    = 25;
  localparam logic [12:0] MinRecip    = 13'd4370;

  // sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QDAY,
    ST_RDAY,
    ST_QHOUR,
    ST_RHOUR,
    ST_QMIN,
    ST_RMIN,
    ST_YEAR,
    ST_MONTH,
    ST_EMIT
  } step_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_QUOT,
    OP_REM,
    OP_YEAR,
    OP_MONTH,
    OP_EMIT
  } op_t;

  // divisor select for the quotient and remainder steps
  typedef enum logic [1:0] {
    SEL_DAY,
    SEL_HOUR,
    SEL_MIN
  } sel_t;

  // one control word: operation, divisor, exit target
  typedef struct packed {
    op_t   op;
    sel_t  sel;
    step_t tgt;
  } ucode_t;

  // microprogram: each step repeats until its exit condition, then jumps to tgt
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    case (s)
      ST_IDLE:  w = '{op: OP_LOAD,  sel: SEL_DAY,  tgt: ST_QDAY};
      ST_QDAY:  w = '{op: OP_QUOT,  sel: SEL_DAY,  tgt: ST_RDAY};
      ST_RDAY:  w = '{op: OP_REM,   sel: SEL_DAY,  tgt: ST_QHOUR};
      ST_QHOUR: w = '{op: OP_QUOT,  sel: SEL_HOUR, tgt: ST_RHOUR};
      ST_RHOUR: w = '{op: OP_REM,   sel: SEL_HOUR, tgt: ST_QMIN};
      ST_QMIN:  w = '{op: OP_QUOT,  sel: SEL_MIN,  tgt: ST_RMIN};
      ST_RMIN:  w = '{op: OP_REM,   sel: SEL_MIN,  tgt: ST_YEAR};
      ST_YEAR:  w = '{op: OP_YEAR,  sel: SEL_DAY,  tgt: ST_MONTH};
      ST_MONTH: w = '{op: OP_MONTH, sel: SEL_DAY,  tgt: ST_EMIT};
      ST_EMIT:  w = '{op: OP_EMIT,  sel: SEL_DAY,  tgt: ST_IDLE};
      default:  w = '{op: OP_EMIT,  sel: SEL_DAY,  tgt: ST_IDLE};
    endcase
    return w;
  endfunction

  // divisor constant for each remainder step
  function automatic logic [DaysW-1:0] div_const(input sel_t sel);
    logic [DaysW-1:0] d;
    case (sel)
      SEL_DAY:  d = SecsPerDay;
      SEL_HOUR: d = SecsPerHour;
      SEL_MIN:  d = SecsPerMin;
      default:  d = SecsPerMin;
    endcase
    return d;
  endfunction

  // days in a month, february follows the leap flag
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] l;
    case (m)
      4'd1:    l = 5'd31;
      4'd2:    l = leap ? 5'd29 : 5'd28;
      4'd3:    l = 5'd31;
      4'd4:    l = 5'd30;
      4'd5:    l = 5'd31;
      4'd6:    l = 5'd30;
      4'd7:    l = 5'd31;
      4'd8:    l = 5'd31;
      4'd9:    l = 5'd30;
      4'd10:   l = 5'd31;
      4'd11:   l = 5'd30;
      4'd12:   l = 5'd31;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

// ----- hdl/epoch_to_calendar_time.sv -----
// The microcoded sequencer runs three reciprocal quotient steps and three remainder steps,
// then one year step and one month step per cycle, and holds in emit while a stalled result
// waits; it takes no new word until it has returned to idle.
// Reset (rst_n low, synchronous) returns the sequencer to idle and clears out_valid.
`include "epoch_to_calendar_time_macros.svh"

module epoch_to_calendar_time (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [e2ct_pkg::EpochW-1:0]     in_epoch_seconds,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [e2ct_pkg::YearW-1:0]      out_cal_year,
  output logic [e2ct_pkg::MonthW-1:0]     out_cal_month,
  output logic [e2ct_pkg::DayW-1:0]       out_cal_day,
  output logic [e2ct_pkg::HourW-1:0]      out_cal_hour,
  output logic [e2ct_pkg::MinuteW-1:0]    out_cal_minute,
  output logic [e2ct_pkg::SecondW-1:0]    out_cal_second
);
  import e2ct_pkg::*;

  // sequencer state
  step_t             step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  // datapath registers
  logic [EpochW-1:0]  rem_r, rem_nxt;
  logic [DaysW-1:0]   days_r, days_nxt;
  logic [YearW-1:0]   year_r, year_nxt;
  logic [MonthW-1:0]  month_r, month_nxt;
  logic [HourW-1:0]   hour_r, hour_nxt;
  logic [MinuteW-1:0] min_r, min_nxt;
  logic [1:0]         yr4_r, yr4_nxt;
  logic [6:0]         yr100_r, yr100_nxt;
  logic [8:0]         yr400_r, yr400_nxt;

  // output register
  logic [YearW-1:0]   out_cal_year_r;
  logic [MonthW-1:0]  out_cal_month_r;
  logic [DayW-1:0]    out_cal_day_r;
  logic [HourW-1:0]   out_cal_hour_r;
  logic [MinuteW-1:0] out_cal_minute_r;
  logic [SecondW-1:0] out_cal_second_r;

  // decoded control word and shared datapath terms
  ucode_t               uw;
  logic [DaysW-1:0]     divisor;
  logic [DayProdW-1:0]  day_prod;
  logic [HourProdW-1:0] hour_prod;
  logic [MinProdW-1:0]  min_prod;
  logic [DaysW-1:0]     quot;
  logic [CandW-1:0]     back;
  logic                 leap;
  logic [DaysW-1:0]     ylen;
  logic [DayW-1:0]      mlen;
  logic                 year_fit;
  logic                 month_fit;
  logic                 out_free;
  logic                 step_exit;
  logic                 out_load;

  // control word fetch and shared datapath terms
  always_comb begin
    uw        = ucode_rom(step_r);
    divisor   = div_const(uw.sel);
    day_prod  = DayProdW'(rem_r[EpochW-1:DayPreShift]) * DayProdW'(DayRecip);
    hour_prod = HourProdW'(rem_r[HourInW-1:0]) * HourProdW'(HourRecip);
    min_prod  = MinProdW'(rem_r[MinInW-1:0]) * MinProdW'(MinRecip);
    case (uw.sel)
      SEL_DAY:  quot = days_r;
      SEL_HOUR: quot = DaysW'(hour_r);
      SEL_MIN:  quot = DaysW'(min_r);
      default:  quot = days_r;
    endcase
    back      = CandW'(quot) * CandW'(divisor);
    leap      = (yr4_r == 2'd0) && ((yr100_r != 7'd0) || (yr400_r == 9'd0));
    ylen      = leap ? DaysW'(DaysLeapYear) : DaysW'(DaysYear);
    year_fit  = days_r < ylen;
    mlen      = month_len(month_r, leap);
    month_fit = (days_r < DaysW'(mlen)) || (month_r == MonthsPerYear);
    out_free  = !out_valid_r || !out_stall;
  end

  // exit condition of the current step
  always_comb begin
    case (uw.op)
      OP_LOAD:  step_exit = in_valid;
      OP_QUOT:  step_exit = 1'b1;
      OP_REM:   step_exit = 1'b1;
      OP_YEAR:  step_exit = year_fit;
      OP_MONTH: step_exit = month_fit;
      OP_EMIT:  step_exit = out_free;
      default:  step_exit = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    step_nxt = step_r;
    if (step_exit) begin
      step_nxt = uw.tgt;
    end
  end

  // handshake and output register load
  always_comb begin
    in_stall      = (step_r != ST_IDLE);
    out_load      = (uw.op == OP_EMIT) && out_free;
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  // datapath operations driven by the control word
  always_comb begin
    rem_nxt   = rem_r;
    days_nxt  = days_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    yr4_nxt   = yr4_r;
    yr100_nxt = yr100_r;
    yr400_nxt = yr400_r;
    case (uw.op)
      OP_LOAD: begin
        if (in_valid) begin
          rem_nxt   = in_epoch_seconds;
          year_nxt  = FirstYear;
          month_nxt = MonthJan;
          yr4_nxt   = Y4Init;
          yr100_nxt = Y100Init;
          yr400_nxt = Y400Init;
        end
      end
      OP_QUOT: begin
        // quotient by reciprocal multiplication, exact over the remainder range
        case (uw.sel)
          SEL_DAY:  days_nxt = DaysW'(day_prod[DayProdW-1:DayShift]);
          SEL_HOUR: hour_nxt = hour_prod[HourShift+HourW-1:HourShift];
          SEL_MIN:  min_nxt  = min_prod[MinShift+MinuteW-1:MinShift];
          default:  ;
        endcase
      end
      OP_REM: begin
        // keep what is left below one unit of the current divisor
        rem_nxt = rem_r - back[EpochW-1:0];
      end
      OP_YEAR: begin
        // consume one whole year of days
        if (!year_fit) begin
          days_nxt  = days_r - ylen;
          year_nxt  = year_r + 12'd1;
          yr4_nxt   = yr4_r + 2'd1;
          yr100_nxt = (yr100_r == Y100Last) ? 7'd0 : yr100_r + 7'd1;
          yr400_nxt = (yr400_r == Y400Last) ? 9'd0 : yr400_r + 9'd1;
        end
      end
      OP_MONTH: begin
        // consume one whole month of days
        if (!month_fit) begin
          days_nxt  = days_r - DaysW'(mlen);
          month_nxt = month_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    days_r  <= days_nxt;
    year_r  <= year_nxt;
    month_r <= month_nxt;
    hour_r  <= hour_nxt;
    min_r   <= min_nxt;
    yr4_r   <= yr4_nxt;
    yr100_r <= yr100_nxt;
    yr400_r <= yr400_nxt;
  end

  // output word register, remainder is the second of the minute
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cal_year_r   <= year_r;
      out_cal_month_r  <= month_r;
      out_cal_day_r    <= days_r[DayW-1:0] + 5'd1;
      out_cal_hour_r   <= hour_r;
      out_cal_minute_r <= min_r;
      out_cal_second_r <= rem_r[SecondW-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cal_year   = out_cal_year_r;
  assign out_cal_month  = out_cal_month_r;
  assign out_cal_day    = out_cal_day_r;
  assign out_cal_hour   = out_cal_hour_r;
  assign out_cal_minute = out_cal_minute_r;
  assign out_cal_second = out_cal_second_r;

  // checks on the sequencer and datapath
  `E2CT_IMPLY_NEXT(a_accept_starts, in_valid && !in_stall,
    (step_r == ST_QDAY) && (year_r == FirstYear),
    "accepted word did not start the day division")
  `E2CT_IMPLY(a_day_rem_bound, step_r == ST_QHOUR, rem_r < EpochW'(SecsPerDay),
    "seconds of day out of range after day division")
  `E2CT_IMPLY(a_doy_in_year, step_r == ST_MONTH, days_r < ylen,
    "day of year not below year length in month walk")
  `E2CT_IMPLY_NEXT(a_result_range, out_load,
    out_valid_r && (out_cal_month_r != 4'd0) && (out_cal_month_r <= MonthsPerYear) &&
    (out_cal_day_r != 5'd0) && (out_cal_hour_r < 5'd24),
    "result word out of calendar range")

endmodule

// ----- tb/tb_epoch_to_calendar_time.sv -----
// self-checking testbench for the epoch seconds to calendar date and time converter
`timescale 1ns / 100ps

module tb_epoch_to_calendar_time;
  import e2ct_pkg::*;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned PhaseWords  = 250;
  localparam int unsigned DaySecs     = 86400;
  localparam int unsigned HourSecs    = 3600;
  localparam int unsigned MinSecs     = 60;
  localparam int unsigned EpochYear   = 1970;
  localparam longint      EpochMax    = 64'd4294967295;

  // one calendar result word
  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } cal_time_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [EpochW-1:0]  in_epoch_seconds = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [YearW-1:0]   out_cal_year;
  logic [MonthW-1:0]  out_cal_month;
  logic [DayW-1:0]    out_cal_day;
  logic [HourW-1:0]   out_cal_hour;
  logic [MinuteW-1:0] out_cal_minute;
  logic [SecondW-1:0] out_cal_second;

  cal_time_t   pending_dates [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  epoch_to_calendar_time dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cal_year     (out_cal_year),
    .out_cal_month    (out_cal_month),
    .out_cal_day      (out_cal_day),
    .out_cal_hour     (out_cal_hour),
    .out_cal_minute   (out_cal_minute),
    .out_cal_second   (out_cal_second)
  );

  always #1 clk = ~clk;

  // gregorian leap rule
  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // expected calendar date and time for one epoch second count
  function automatic cal_time_t to_calendar(input logic [EpochW-1:0] secs);
    int unsigned days_in_month [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int unsigned day_count;
    int unsigned sec_of_day;
    int unsigned year_len;
    int unsigned y;
    int unsigned mon;
    int unsigned mlen;
    int unsigned m;
    cal_time_t   r;
    day_count  = secs / DaySecs;
    sec_of_day = secs % DaySecs;
    // strip whole years from the day count
    y = EpochYear;
    year_len = leap_year(y) ? 366 : 365;
    while (day_count >= year_len) begin
      day_count -= year_len;
      y++;
      year_len = leap_year(y) ? 366 : 365;
    end
    // walk the months with a one-based day of year
    mon = 12;
    day_count += 1;
    for (m = 0; m < 12; m++) begin
      mlen = (m == 1 && leap_year(y)) ? 29 : days_in_month[m];
      if (day_count <= mlen) begin
        mon = m + 1;
        break;
      end
      day_count -= mlen;
    end
    r.year   = YearW'(y);
    r.month  = MonthW'(mon);
    r.day    = DayW'(day_count);
    r.hour   = HourW'(sec_of_day / HourSecs);
    r.minute = MinuteW'((sec_of_day % HourSecs) / MinSecs);
    r.second = SecondW'(sec_of_day % MinSecs);
    return r;
  endfunction

  // epoch seconds at midnight on january 1 of year y
  function automatic longint year_start_secs(input int unsigned y);
    longint      total;
    int unsigned k;
    total = 0;
    for (k = EpochYear; k < y; k++) begin
      total += longint'(leap_year(k) ? 366 : 365) * DaySecs;
    end
    return total;
  endfunction

  // random epoch word, biased toward new year and the end of february
  function automatic logic [EpochW-1:0] pick_epoch();
    longint      t;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom();
    t = year_start_secs($urandom_range(EpochYear, 2106));
    if (sel < 85) begin
      t += longint'($urandom_range(0, 4 * DaySecs)) - longint'(2 * DaySecs);
    end else begin
      t += longint'(58 + $urandom_range(0, 2)) * DaySecs + $urandom_range(0, DaySecs - 1);
    end
    if (t < 0 || t > EpochMax) return $urandom();
    return t[EpochW-1:0];
  endfunction

  // reset once at the start
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d words outstanding", $time, pending_dates.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each result word with the oldest pending expectation
  always @(posedge clk) begin
    cal_time_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: result word with no pending input, actual %0d-%0d-%0d %0d:%0d:%0d",
                 $time, out_cal_year, out_cal_month, out_cal_day, out_cal_hour,
                 out_cal_minute, out_cal_second);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        check_field("year", 32'(want.year), 32'(out_cal_year));
        check_field("month", 32'(want.month), 32'(out_cal_month));
        check_field("day", 32'(want.day), 32'(out_cal_day));
        check_field("hour", 32'(want.hour), 32'(out_cal_hour));
        check_field("minute", 32'(want.minute), 32'(out_cal_minute));
        check_field("second", 32'(want.second), 32'(out_cal_second));
      end
    end
  end

  // offer one word, with a random idle gap first, and record its expected date
  task automatic send_word(input logic [EpochW-1:0] secs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_dates.push_back(to_calendar(secs));
  endtask

  // drop valid and wait for every outstanding result word
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_words(input int unsigned count);
    repeat (count) send_word(pick_epoch());
  endtask

  // field extremes, leap rules, days past the 255th and the largest input
  task automatic test_directed_dates();
    send_word('0);
    send_word(EpochW'(DaySecs - 1));
    send_word(EpochW'(DaySecs));
    send_word(EpochW'(year_start_secs(1971) - 1));
    send_word(EpochW'(year_start_secs(1971) + 255 * DaySecs));
    send_word(EpochW'(year_start_secs(1972) + 59 * DaySecs));
    send_word(EpochW'(year_start_secs(1972) + 365 * DaySecs + DaySecs - 1));
    send_word(EpochW'(year_start_secs(1999) + 30 * DaySecs + DaySecs - 1));
    send_word(EpochW'(year_start_secs(1999) + 333 * DaySecs));
    send_word(EpochW'(year_start_secs(2000) + 59 * DaySecs));
    send_word(EpochW'(year_start_secs(2000) + 60 * DaySecs));
    send_word(EpochW'(year_start_secs(2000) + 365 * DaySecs));
    send_word(EpochW'(year_start_secs(2100) + 58 * DaySecs + DaySecs - 1));
    send_word(EpochW'(year_start_secs(2100) + 59 * DaySecs));
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);
    send_word(EpochW'(year_start_secs(2106)));
    send_word(32'hFFFF_FFFE);
    send_word(32'hFFFF_FFFF);
  endtask

  // sender holds off until the block has emptied, then resumes
  task automatic test_drain_pause();
    send_random_words(4);
    wait_drained();
    send_random_words(4);
    wait_drained();
  endtask

  task automatic test_random_steady();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_words(PhaseWords);
  endtask

  task automatic test_random_sender_gaps();
    send_idle_pct = 64;
    recv_stall_pct = 0;
    send_random_words(PhaseWords);
  endtask

  task automatic test_random_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 64;
    send_random_words(PhaseWords);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 9;
    recv_stall_pct = 9;
    send_random_words(PhaseWords);
  endtask

  // test sequence
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    test_directed_dates();
    test_drain_pause();
    test_random_steady();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
